// ----- hdl/ptd_pkg.sv -----
// Package for the periodic task dispatcher: shared constants, codes and types.
// Has no dependencies; every other file of the block imports it.
package ptd_pkg;

  localparam int TASK_SLOTS_DEF   = 8;
  localparam int LOWEST_LEVEL_DEF = 14;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_DISPATCH = 2'd2;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_GE,
    ALU_REARM
  } alu_mode_t;

  typedef struct packed {
    logic add_we;
    logic due_we;
  } tbl_ctl_t;

endpackage

// ----- hdl/ptd_alu.sv -----
// Shared 33-bit adder of the dispatcher: wrapping add, unsigned compare and
// clamped re-arm. Depends on ptd_pkg.
module ptd_alu (
  input  ptd_pkg::alu_mode_t mode,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output logic [31:0]        y,
  output logic               ge
);
  import ptd_pkg::*;

  logic [31:0] b_op;
  logic [32:0] sum;

  always_comb begin
    b_op = (mode == ALU_GE) ? ~b : b;
    sum  = {1'b0, a} + {1'b0, b_op} + {32'd0, (mode == ALU_GE)};
    ge   = sum[32];
    if (mode == ALU_REARM && sum[32]) begin
      y = ~b;
    end else begin
      y = sum[31:0];
    end
  end

endmodule

// ----- hdl/ptd_table.sv -----
// Task table of the dispatcher: tag, period, due tick and level per slot.
// One read address, one write address per cycle. Depends on ptd_pkg.
module ptd_table #(
  parameter int TASK_SLOTS = ptd_pkg::TASK_SLOTS_DEF,
  parameter int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  logic                        clk,
  input  ptd_pkg::tbl_ctl_t           ctl,
  input  logic [SLOT_W-1:0]           wr_idx,
  input  logic [7:0]                  wr_tag,
  input  logic [31:0]                 wr_period,
  input  logic [31:0]                 wr_due,
  input  logic [3:0]                  wr_level,
  input  logic [SLOT_W-1:0]           rd_idx,
  output logic [7:0]                  rd_tag,
  output logic [31:0]                 rd_period,
  output logic [31:0]                 rd_due,
  output logic [TASK_SLOTS-1:0][3:0]  levels
);
  import ptd_pkg::*;

  logic [7:0]                 tag_q    [TASK_SLOTS];
  logic [31:0]                period_q [TASK_SLOTS];
  logic [31:0]                due_q    [TASK_SLOTS];
  logic [TASK_SLOTS-1:0][3:0] level_q;

  always_ff @(posedge clk) begin
    if (ctl.add_we) begin
      tag_q[wr_idx]    <= wr_tag;
      period_q[wr_idx] <= wr_period;
      level_q[wr_idx]  <= wr_level;
      due_q[wr_idx]    <= wr_due;
    end else if (ctl.due_we) begin
      due_q[wr_idx] <= wr_due;
    end
  end

  assign rd_tag    = tag_q[rd_idx];
  assign rd_period = period_q[rd_idx];
  assign rd_due    = due_q[rd_idx];
  assign levels    = level_q;

endmodule

// ----- hdl/periodic_task_dispatcher_unit.sv -----
// Top level of the periodic task dispatcher: sequencer, output register and
// instances of ptd_table and ptd_alu. Depends on ptd_pkg.
//
// One transaction is taken at a time. Add, tick, an unused op and a dispatch
// on an already dispatched tick pass through the accept state ST_IDLE and the
// execute state ST_EXEC. A dispatch on a new tick goes on from ST_EXEC to
// ST_SCAN for one due compare per filled slot (skipped with an empty table),
// then to ST_SEEK, which walks the levels up from level 0 to the highest due
// level and gives one result and one re-arm per due task. With no task due it
// gives one empty result. All compares, due sums and re-arms run
// through the one shared 33-bit adder. A finished result waits in the output
// register, and a step that produces a result holds while that register is
// full and m_tready is low.
module periodic_task_dispatcher_unit #(
  parameter int TASK_SLOTS   = ptd_pkg::TASK_SLOTS_DEF,
  parameter int LOWEST_LEVEL = ptd_pkg::LOWEST_LEVEL_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // handler_tag[7:0], period[39:8], priority_req[43:40], zero fill above
  input  logic [ptd_pkg::IN_DATA_W-1:0]   s_tdata,
  // op[1:0]
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // accepted[0], run_valid[1], task_slot[4:2], run_tag[12:5], tick_now[44:13]
  output logic [ptd_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast
);
  import ptd_pkg::*;

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TASK_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SEEK
  } state_t;

  state_t                     state;
  logic [1:0]                 op_r;
  logic [7:0]                 tag_r;
  logic [31:0]                per_r;
  logic [3:0]                 pri_r;
  logic [31:0]                tick;
  logic [31:0]                last_seen;
  logic [CNT_W-1:0]           used;
  logic [SLOT_W-1:0]          scan_idx;
  logic [TASK_SLOTS-1:0]      mask;
  logic [3:0]                 lvl;

  logic                       out_acc;
  logic                       out_run;
  logic [2:0]                 out_slot;
  logic [7:0]                 out_tag;
  logic [31:0]                out_tick;

  tbl_ctl_t                   tbl_ctl;
  alu_mode_t                  alu_mode;
  logic [31:0]                alu_b;
  logic [31:0]                alu_y;
  logic                       alu_ge;
  logic [SLOT_W-1:0]          rd_idx;
  logic [SLOT_W-1:0]          wr_idx;
  logic [3:0]                 wr_level;
  logic [7:0]                 rd_tag;
  logic [31:0]                rd_period;
  logic [31:0]                rd_due;
  logic [TASK_SLOTS-1:0][3:0] levels;

  logic                       out_free;
  logic                       out_load;
  logic                       add_ok;
  logic [TASK_SLOTS-1:0]      hits;
  logic [SLOT_W-1:0]          sel_idx;
  logic [TASK_SLOTS-1:0]      sel_onehot;
  logic [TASK_SLOTS-1:0]      mask_rest;
  logic [31:0]                sel_wide;

  assign s_tready = !rst && (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free &&
                    (((state == ST_EXEC) && !((op_r == OP_DISPATCH) && (tick != last_seen))) ||
                     ((state == ST_SEEK) && ((mask == '0) || (hits != '0))));
  assign add_ok   = (used < CNT_W'(TASK_SLOTS)) && (tag_r != 8'd0);
  assign m_tdata  = {3'd0, out_tick, out_tag, out_slot, out_run, out_acc};
  assign sel_wide = 32'(sel_idx);

  always_comb begin
    hits       = '0;
    sel_idx    = '0;
    sel_onehot = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      hits[i] = mask[i] && (levels[i] == lvl);
    end
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (hits[i]) begin
        sel_idx    = SLOT_W'(i);
        sel_onehot = TASK_SLOTS'(1) << i;
      end
    end
    mask_rest = mask & ~sel_onehot;
  end

  always_comb begin
    alu_mode = ALU_ADD;
    alu_b    = 32'd1;
    case (state)
      ST_EXEC: begin
        if (op_r == OP_ADD) begin
          alu_b = per_r;
        end
      end
      ST_SCAN: begin
        alu_mode = ALU_GE;
        alu_b    = rd_due;
      end
      ST_SEEK: begin
        alu_mode = ALU_REARM;
        alu_b    = rd_period;
      end
      default: begin
        alu_b = 32'd1;
      end
    endcase
  end

  always_comb begin
    rd_idx         = (state == ST_SCAN) ? scan_idx : sel_idx;
    wr_idx         = (state == ST_SEEK) ? sel_idx : SLOT_W'(used);
    wr_level       = (pri_r > 4'(LOWEST_LEVEL)) ? 4'(LOWEST_LEVEL) : pri_r;
    tbl_ctl.add_we = (state == ST_EXEC) && (op_r == OP_ADD) && add_ok && out_free;
    tbl_ctl.due_we = (state == ST_SEEK) && (hits != '0) && out_free;
  end

  ptd_alu u_alu (
    .mode (alu_mode),
    .a    (tick),
    .b    (alu_b),
    .y    (alu_y),
    .ge   (alu_ge)
  );

  ptd_table #(
    .TASK_SLOTS (TASK_SLOTS),
    .SLOT_W     (SLOT_W)
  ) u_table (
    .clk       (clk),
    .ctl       (tbl_ctl),
    .wr_idx    (wr_idx),
    .wr_tag    (tag_r),
    .wr_period (per_r),
    .wr_due    (alu_y),
    .wr_level  (wr_level),
    .rd_idx    (rd_idx),
    .rd_tag    (rd_tag),
    .rd_period (rd_period),
    .rd_due    (rd_due),
    .levels    (levels)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tick      <= '0;
      last_seen <= '0;
      used      <= '0;
      mask      <= '0;
      lvl       <= '0;
      scan_idx  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op_r  <= s_tuser;
            tag_r <= s_tdata[7:0];
            per_r <= s_tdata[39:8];
            pri_r <= s_tdata[43:40];
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (op_r == OP_DISPATCH && tick != last_seen) begin
            last_seen <= tick;
            mask      <= '0;
            lvl       <= '0;
            scan_idx  <= '0;
            state     <= (used == '0) ? ST_SEEK : ST_SCAN;
          end else if (out_free) begin
            m_tvalid <= 1'b1;
            out_acc  <= (op_r == OP_ADD) && add_ok;
            out_run  <= 1'b0;
            out_slot <= ((op_r == OP_ADD) && add_ok) ? 3'(used) : 3'd0;
            out_tag  <= '0;
            out_tick <= (op_r == OP_TICK) ? alu_y : tick;
            m_tlast  <= 1'b1;
            if (op_r == OP_ADD && add_ok) begin
              used <= used + CNT_W'(1);
            end
            if (op_r == OP_TICK) begin
              tick <= alu_y;
            end
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          mask[scan_idx] <= alu_ge && (rd_tag != 8'd0);
          scan_idx       <= scan_idx + SLOT_W'(1);
          if (CNT_W'(scan_idx) == used - CNT_W'(1)) begin
            state <= ST_SEEK;
          end
        end
        ST_SEEK: begin
          if (mask == '0) begin
            if (out_free) begin
              m_tvalid <= 1'b1;
              out_acc  <= 1'b0;
              out_run  <= 1'b0;
              out_slot <= '0;
              out_tag  <= '0;
              out_tick <= tick;
              m_tlast  <= 1'b1;
              state    <= ST_IDLE;
            end
          end else if (hits == '0) begin
            lvl <= lvl + 4'd1;
          end else if (out_free) begin
            m_tvalid <= 1'b1;
            out_acc  <= 1'b0;
            out_run  <= 1'b1;
            out_slot <= sel_wide[2:0];
            out_tag  <= rd_tag;
            out_tick <= tick;
            m_tlast  <= (mask_rest == '0);
            mask     <= mask_rest;
            if (mask_rest == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/ptd_checker.sv -----
// Port-level checker for the periodic task dispatcher, bound to the top level.
// Depends on periodic_task_dispatcher_unit and ptd_pkg.
module ptd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ptd_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic                            m_tlast
);
  import ptd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Result transaction changed while stalled.");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("Accepted and run flags set in one result.");

  a_norun_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> m_tlast)
    else $error("A result that runs no task is not final.");

  a_run_tag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[12:5] != 8'd0)
    else $error("Dispatched task carries an empty handler tag.");

endmodule

bind periodic_task_dispatcher_unit ptd_checker u_ptd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- test/tb_periodic_task_dispatcher_unit.sv -----
// Self-checking testbench for periodic_task_dispatcher_unit: directed and random
// add, tick and dispatch transactions checked against a task-table predictor.
// Depends on ptd_pkg and the RTL of the block; needs no other files.
`timescale 1ns / 1ps

module tb_periodic_task_dispatcher_unit;
  import ptd_pkg::*;

  localparam int TASK_SLOTS = TASK_SLOTS_DEF;
  localparam int LOWEST_LEVEL = LOWEST_LEVEL_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_ITEMS = 85;

  typedef struct packed {
    logic        accepted;
    logic        run_valid;
    logic [2:0]  slot;
    logic [7:0]  tag;
    logic [31:0] tick;
    logic        last;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  logic [31:0] period_tbl [TASK_SLOTS];
  logic [31:0] due_tbl [TASK_SLOTS];
  logic [3:0]  level_tbl [TASK_SLOTS];
  logic [7:0]  tag_tbl [TASK_SLOTS];
  int          used_cnt;
  logic [31:0] tick_cnt;
  logic [31:0] last_disp_tick;

  result_t pending_results [$];
  int      error_count;
  int      hold_seq;

  periodic_task_dispatcher_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  function automatic void clear_schedule();
    for (int i = 0; i < TASK_SLOTS; i++) begin
      period_tbl[i] = '0;
      due_tbl[i] = '0;
      level_tbl[i] = LOWEST_LEVEL[3:0];
      tag_tbl[i] = '0;
    end
    used_cnt = 0;
    tick_cnt = '0;
    last_disp_tick = '0;
  endfunction

  function automatic void predict_schedule(input logic [1:0] op, input logic [7:0] tag,
                                           input logic [31:0] per, input logic [3:0] pri);
    result_t     r;
    logic [32:0] sum;
    int          runs;
    r = '0;
    r.last = 1'b1;
    runs = 0;
    case (op)
      OP_ADD: begin
        if (used_cnt < TASK_SLOTS && tag != 8'd0) begin
          tag_tbl[used_cnt] = tag;
          period_tbl[used_cnt] = per;
          due_tbl[used_cnt] = tick_cnt + per;
          level_tbl[used_cnt] = (pri > LOWEST_LEVEL) ? LOWEST_LEVEL[3:0] : pri;
          r.accepted = 1'b1;
          r.slot = used_cnt[2:0];
          used_cnt++;
        end
      end
      OP_TICK: begin
        tick_cnt = tick_cnt + 32'd1;
      end
      OP_DISPATCH: begin
        if (tick_cnt != last_disp_tick) begin
          last_disp_tick = tick_cnt;
          for (int lv = 0; lv <= LOWEST_LEVEL; lv++) begin
            for (int i = 0; i < used_cnt; i++) begin
              if (level_tbl[i] == lv && tag_tbl[i] != 8'd0 && tick_cnt >= due_tbl[i]) begin
                sum = {1'b0, tick_cnt} + {1'b0, period_tbl[i]};
                due_tbl[i] = sum[32] ? (32'hFFFF_FFFF - period_tbl[i]) : sum[31:0];
                r.run_valid = 1'b1;
                r.slot = i[2:0];
                r.tag = tag_tbl[i];
                r.tick = tick_cnt;
                r.last = 1'b0;
                pending_results.push_back(r);
                runs++;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (runs > 0) begin
      r = pending_results.pop_back();
      r.last = 1'b1;
      pending_results.push_back(r);
    end else begin
      r.tick = tick_cnt;
      pending_results.push_back(r);
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] tag,
                           input logic [31:0] per, input logic [3:0] pri);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {4'b0000, pri, per, tag};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_schedule(op, tag, per, pri);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    pause_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic send_random_item();
    logic [1:0]  op;
    logic [31:0] per;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) op = OP_ADD;
    else if (pick < 12) op = OP_UNUSED;
    else if (pick < 55) op = OP_TICK;
    else op = OP_DISPATCH;
    per = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8) : $urandom;
    send_item(op, 8'($urandom), per, 4'($urandom_range(0, 15)));
  endtask

  task automatic test_idle_dispatch();
    send_item(OP_DISPATCH, 8'h00, 32'h0, 4'h0);
    send_item(OP_UNUSED, 8'hC3, 32'h1234_5678, 4'h9);
    send_item(OP_TICK, 8'h00, 32'h0, 4'h0);
    send_item(OP_DISPATCH, 8'h00, 32'h0, 4'h0);
    send_item(OP_DISPATCH, 8'h00, 32'h0, 4'h0);
    drain_results();
  endtask

  task automatic test_add_and_rearm();
    send_item(OP_ADD, 8'h00, 32'hFFFF_FFFF, 4'hF);
    send_item(OP_TICK, 8'h00, 32'h0, 4'h0);
    send_item(OP_TICK, 8'h00, 32'h0, 4'h0);
    send_item(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 4'hF);
    send_item(OP_ADD, 8'h01, 32'h0, 4'h0);
    send_item(OP_ADD, 8'h5A, 32'd3, 4'd14);
    send_item(OP_ADD, 8'hA5, 32'hFFFF_FFFE, 4'd7);
    send_item(OP_DISPATCH, 8'h00, 32'h0, 4'h0);
    send_item(OP_DISPATCH, 8'h00, 32'h0, 4'h0);
    send_item(OP_TICK, 8'h00, 32'h0, 4'h0);
    send_item(OP_DISPATCH, 8'h00, 32'h0, 4'h0);
    drain_results();
  endtask

  task automatic test_full_table();
    send_item(OP_ADD, 8'h11, 32'd1, 4'd3);
    send_item(OP_ADD, 8'h22, 32'd2, 4'd0);
    send_item(OP_ADD, 8'h44, 32'd5, 4'd9);
    send_item(OP_ADD, 8'h88, 32'd7, 4'd12);
    send_item(OP_ADD, 8'h33, 32'd1, 4'd1);
    send_item(OP_TICK, 8'h00, 32'h0, 4'h0);
    send_item(OP_DISPATCH, 8'h00, 32'h0, 4'h0);
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_seq++;
    @(posedge clk);
    for (int i = 0; i < 12; i++) begin
      send_item((i % 2 == 0) ? OP_TICK : OP_DISPATCH, 8'($urandom), $urandom,
                4'($urandom));
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    int burst_left;
    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
      end
      send_random_item();
      burst_left--;
    end
    pause_sender(1);
  endtask

  initial begin : receiver
    int hold_seen;
    int hold_cnt;
    int mode;
    int mode_left;
    m_tready = 1'b0;
    hold_seen = 0;
    hold_cnt = 0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(4, 40);
        end
        mode_left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 1);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing expected", m_tdata[31:0], 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[0] !== want.accepted)
          flag_mismatch("accepted", 32'(m_tdata[0]), 32'(want.accepted));
        if (m_tdata[1] !== want.run_valid)
          flag_mismatch("run_valid", 32'(m_tdata[1]), 32'(want.run_valid));
        if (m_tdata[4:2] !== want.slot)
          flag_mismatch("task_slot", 32'(m_tdata[4:2]), 32'(want.slot));
        if (m_tdata[12:5] !== want.tag)
          flag_mismatch("run_tag", 32'(m_tdata[12:5]), 32'(want.tag));
        if (m_tdata[44:13] !== want.tick) flag_mismatch("tick_now", m_tdata[44:13], want.tick);
        if (m_tdata[47:45] !== 3'b000)
          flag_mismatch("zero fill", 32'(m_tdata[47:45]), 32'h0);
        if (m_tlast !== want.last) flag_mismatch("last", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int waited;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    error_count = 0;
    hold_seq = 0;
    clear_schedule();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_dispatch();
    test_add_and_rearm();
    test_full_table();
    test_backpressure();
    test_random_traffic();

    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      flag_mismatch("results never delivered", 32'(pending_results.size()), 32'h0);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ptd_pkg.sv
hdl/ptd_alu.sv
hdl/ptd_table.sv
hdl/periodic_task_dispatcher_unit.sv
hdl/ptd_checker.sv
test/tb_periodic_task_dispatcher_unit.sv
